@@ rtl/core/tevme_pkg.sv @@
// Shared types, codes and the microcode table of the touch event message encoder.
package tevme_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RUN
  } state_e;

  typedef enum logic [1:0] {
    OP_CONST,
    OP_CONST_N,
    OP_VARINT,
    OP_ACTION
  } op_e;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_X,
    LD_Y
  } load_e;

  // One microcode word: byte source, shift register load on leaving the step,
  // end-of-program mark and the constant byte.
  typedef struct packed {
    op_e        op;
    load_e      load;
    logic       last;
    logic [7:0] konst;
  } ctrl_t;

  typedef struct packed {
    logic adv;
    logic more;
  } emit_stat_t;

  localparam int StepW = 5;
  typedef logic [StepW-1:0] step_t;

  localparam logic [4:0] EV_SYNC = 5'd0;
  localparam logic [4:0] EV_KEY  = 5'd1;
  localparam logic [4:0] EV_ABS  = 5'd3;

  localparam logic [9:0] CODE_POS_X = 10'h035;
  localparam logic [9:0] CODE_POS_Y = 10'h036;
  localparam logic [9:0] CODE_TOUCH = 10'h14a;

  localparam logic [1:0] ACT_DOWN = 2'd0;
  localparam logic [1:0] ACT_UP   = 2'd1;
  localparam logic [1:0] ACT_MOVE = 2'd2;

  localparam logic [12:0] RAW_FULL = 13'd4095;

  localparam logic [7:0] CFG_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_HEIGHT = 8'd1;

  localparam logic [11:0] WIDTH_RST  = 12'd800;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  function automatic ctrl_t mk(op_e op, load_e load, logic last, logic [7:0] konst);
    ctrl_t c;
    c.op    = op;
    c.load  = load;
    c.last  = last;
    c.konst = konst;
    return c;
  endfunction

  // Message program. A varint step repeats while more bytes remain.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      5'd0:    c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h80);
      5'd1:    c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h01);
      5'd2:    c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h08);
      5'd3:    c = mk(OP_VARINT,  LD_NONE, 1'b0, 8'h00);
      5'd4:    c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h1a);
      5'd5:    c = mk(OP_CONST_N, LD_NONE, 1'b0, 8'h09);
      5'd6:    c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h0a);
      5'd7:    c = mk(OP_CONST_N, LD_NONE, 1'b0, 8'h03);
      5'd8:    c = mk(OP_CONST,   LD_X,    1'b0, 8'h08);
      5'd9:    c = mk(OP_VARINT,  LD_NONE, 1'b0, 8'h00);
      5'd10:   c = mk(OP_CONST,   LD_Y,    1'b0, 8'h10);
      5'd11:   c = mk(OP_VARINT,  LD_NONE, 1'b0, 8'h00);
      5'd12:   c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h18);
      5'd13:   c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h00);
      5'd14:   c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h10);
      5'd15:   c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h00);
      5'd16:   c = mk(OP_CONST,   LD_NONE, 1'b0, 8'h18);
      5'd17:   c = mk(OP_ACTION,  LD_NONE, 1'b1, 8'h00);
      default: c = mk(OP_CONST,   LD_NONE, 1'b1, 8'h00);
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/tevme_scale.sv @@
// Position scaler: raw * size / 4095 as a registered multiply and a correction step.
module tevme_scale import tevme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] raw_i,
  input  logic [11:0] size_i,
  output logic        done_o,
  output logic [11:0] quot_o
);

  logic [23:0] prod_q;
  logic        vld_q;
  logic [11:0] hi;
  logic [11:0] lo;
  logic [12:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= raw_i * size_i;
    end
  end

  // p = 4096*hi + lo = 4095*hi + (hi + lo), and hi + lo stays below 2*4095.
  assign hi  = prod_q[23:12];
  assign lo  = prod_q[11:0];
  assign sum = {1'b0, hi} + {1'b0, lo};

  assign quot_o = hi + {11'd0, (sum >= RAW_FULL)};
  assign done_o = vld_q;

endmodule

@@ rtl/core/tevme_seq.sv @@
// Microcode sequencer: step counter, program table lookup and conditional repeat.
module tevme_seq import tevme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  emit_stat_t stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);

  step_t step_q, step_d;
  logic  busy_q, busy_d;
  ctrl_t ctrl;

  assign ctrl   = ucode(step_q);
  assign ctrl_o = ctrl;
  assign busy_o = busy_q;

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    priority if (start_i) begin
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q && stat_i.adv) begin
      priority if (ctrl.op == OP_VARINT && stat_i.more) begin
        step_d = step_q;
      end else if (ctrl.last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

endmodule

@@ rtl/core/tevme_emit.sv @@
// Byte datapath: varint shift register, byte select and the output register.
module tevme_emit import tevme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] ts_i,
  input  logic        busy_i,
  input  ctrl_t       ctrl_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [1:0]  action_i,
  input  logic        tready_i,
  output logic        tvalid_o,
  output logic [7:0]  tdata_o,
  output logic        tlast_o,
  output emit_stat_t  stat_o
);

  logic [62:0] vsr_q;
  logic        more;
  logic        adv;
  logic [2:0]  ncoord;
  logic [7:0]  byte_d;
  logic        tvalid_q;
  logic [7:0]  tdata_q;
  logic        tlast_q;

  assign more = |vsr_q[62:7];
  assign adv  = busy_i && (!tvalid_q || tready_i);

  // Bytes of the three coordinate varints; the third one is always a single zero.
  assign ncoord = 3'd3 + {2'd0, |pos_x_i[11:7]} + {2'd0, |pos_y_i[11:7]};

  always_comb begin
    unique case (ctrl_i.op)
      OP_CONST:   byte_d = ctrl_i.konst;
      OP_CONST_N: byte_d = ctrl_i.konst + {5'd0, ncoord};
      OP_VARINT:  byte_d = {more, vsr_q[6:0]};
      OP_ACTION:  byte_d = {6'd0, action_i};
      default:    byte_d = ctrl_i.konst;
    endcase
  end

  always_ff @(posedge clk_i) begin
    priority if (start_i) begin
      vsr_q <= ts_i;
    end else if (adv && ctrl_i.op == OP_VARINT) begin
      vsr_q <= {7'd0, vsr_q[62:7]};
    end else if (adv && ctrl_i.load == LD_X) begin
      vsr_q <= {51'd0, pos_x_i};
    end else if (adv && ctrl_i.load == LD_Y) begin
      vsr_q <= {51'd0, pos_y_i};
    end else begin
      vsr_q <= vsr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdata_q <= byte_d;
      tlast_q <= ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (adv) begin
      tvalid_q <= 1'b1;
    end else if (tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  assign tvalid_o    = tvalid_q;
  assign tdata_o     = tdata_q;
  assign tlast_o     = tlast_q;
  assign stat_o.adv  = adv;
  assign stat_o.more = more;

endmodule

@@ rtl/core/touch_event_varint_message_encoder_unit.sv @@
// Touch event message encoder: keeps the touch position and action from input
// events and, on a sync event, streams one framed message a byte per transaction.
// A key or ignored event is taken while idle; a position event passes through a
// registered 12x12 multiply, then a constant-4095 correction step; a sync event
// occupies the block while the microcode sequencer emits the message (18 to 28
// bytes), one byte per cycle while the output side keeps taking bytes. The output
// register lets the next event be accepted while the final byte still waits.
// Configuration writes are always taken.
module touch_event_varint_message_encoder_unit import tevme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // event_code[9:0], event_value[21:10],
                                     // timestamp_ns[84:22], zero[87:85]
  input  logic [7:0]  s_axis_tuser,  // event_kind[4:0], zero[7:5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // message_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  state_e      state_q, state_d;
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [11:0] pos_x_q;
  logic [11:0] pos_y_q;
  logic [1:0]  action_q;
  logic        pending_q;
  logic        is_y_q;

  logic [4:0]  ev_type;
  logic [9:0]  ev_code;
  logic [11:0] ev_value;
  logic [62:0] ev_ts;
  logic        acc;
  logic        is_pos;
  logic        is_touch;
  logic        is_sync;
  logic        scale_start;
  logic        scale_done;
  logic [11:0] scale_quot;
  logic [11:0] scale_size;
  ctrl_t       ctrl;
  emit_stat_t  stat;
  logic        busy;

  assign ev_code  = s_axis_tdata[9:0];
  assign ev_value = s_axis_tdata[21:10];
  assign ev_ts    = s_axis_tdata[84:22];
  assign ev_type  = s_axis_tuser[4:0];

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign is_pos   = (ev_type == EV_ABS) && (ev_code == CODE_POS_X || ev_code == CODE_POS_Y);
  assign is_touch = (ev_type == EV_KEY) && (ev_code == CODE_TOUCH);
  assign is_sync  = (ev_type == EV_SYNC);

  assign scale_start = acc && is_pos;
  assign scale_size  = (ev_code == CODE_POS_Y) ? height_q : width_q;

  assign cfg_ready_o = 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && is_pos) begin
          state_d = ST_SCALE;
        end else if (acc && is_sync) begin
          state_d = ST_RUN;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (!busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      action_q  <= ACT_DOWN;
      pending_q <= 1'b0;
      is_y_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_index_i == CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CFG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      if (scale_start) begin
        is_y_q <= (ev_code == CODE_POS_Y);
      end
      if (scale_done && is_y_q) begin
        pos_y_q <= scale_quot;
      end
      if (scale_done && !is_y_q) begin
        pos_x_q <= scale_quot;
      end
      if (acc && is_touch) begin
        pending_q <= 1'b1;
        action_q  <= (ev_value == 12'd1) ? ACT_DOWN : ACT_UP;
      end else if (acc && is_sync) begin
        // Without a key event since the last message the touch counts as a move.
        pending_q <= 1'b0;
        if (!pending_q) begin
          action_q <= ACT_MOVE;
        end
      end
    end
  end

  tevme_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .raw_i   (ev_value),
    .size_i  (scale_size),
    .done_o  (scale_done),
    .quot_o  (scale_quot)
  );

  tevme_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc && is_sync),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  tevme_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (acc && is_sync),
    .ts_i     (ev_ts),
    .busy_i   (busy),
    .ctrl_i   (ctrl),
    .pos_x_i  (pos_x_q),
    .pos_y_i  (pos_y_q),
    .action_i (action_q),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .stat_o   (stat)
  );

endmodule

@@ tb/sv/tevme_msg_checker.sv @@
`timescale 1ns / 1ps
// Watches the event, message and configuration channels and checks every message byte.
module tevme_msg_checker import tevme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ev_valid_i,
  input  logic        ev_ready_i,
  input  logic [87:0] ev_data_i,
  input  logic [7:0]  ev_user_i,
  input  logic        msg_valid_i,
  input  logic        msg_ready_i,
  input  logic [7:0]  msg_data_i,
  input  logic        msg_last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam logic [23:0] MSG_HEADER      = 24'h800108;
  localparam logic [23:0] MSG_FOOTER      = 24'h100018;
  localparam logic [7:0]  SIZE_TAG_OUTER  = 8'h1a;
  localparam logic [7:0]  SIZE_BASE_OUTER = 8'h09;
  localparam logic [7:0]  SIZE_TAG_INNER  = 8'h0a;
  localparam logic [7:0]  SIZE_BASE_INNER = 8'h03;
  localparam logic [7:0]  TAG_X           = 8'h08;
  localparam logic [7:0]  TAG_Y           = 8'h10;
  localparam logic [7:0]  TAG_Z           = 8'h18;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  msg_byte_t   msg_byte_q[$];
  int          err_count = 0;
  int          queued    = 0;

  logic [11:0] width_q  = WIDTH_RST;
  logic [11:0] height_q = HEIGHT_RST;
  logic [11:0] pos_x_q  = '0;
  logic [11:0] pos_y_q  = '0;
  logic [1:0]  action_q = ACT_DOWN;
  logic        key_seen_q = 1'b0;

  assign errors_o  = err_count;
  assign pending_o = queued;

  task automatic report_mismatch(string what);
    $display("%0t ns: message byte mismatch: %s", $time, what);
    err_count++;
  endtask

  function automatic logic [11:0] scale_raw(logic [11:0] raw, logic [11:0] size);
    logic [23:0] prod;
    prod = raw * size;
    return 12'(prod / RAW_FULL);
  endfunction

  function automatic int unsigned leb_len(logic [62:0] v);
    int unsigned n;
    n = 1;
    while (v > 63'd127) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  task automatic push_byte(logic [7:0] data, logic last);
    msg_byte_t b;
    b.data = data;
    b.last = last;
    msg_byte_q.push_back(b);
  endtask

  task automatic push_leb(logic [62:0] v);
    logic more;
    do begin
      more = (v >> 7) != '0;
      push_byte({more, v[6:0]}, 1'b0);
      v = v >> 7;
    end while (more);
  endtask

  // Updates the touch state for one event and queues the bytes a sync produces.
  task automatic encode_event(logic [4:0] ev_type, logic [9:0] code, logic [11:0] value,
                              logic [62:0] ts);
    logic [7:0] coord_len;
    case (ev_type)
      EV_ABS: begin
        if (code == CODE_POS_X) pos_x_q = scale_raw(value, width_q);
        else if (code == CODE_POS_Y) pos_y_q = scale_raw(value, height_q);
      end
      EV_KEY: begin
        if (code == CODE_TOUCH) begin
          key_seen_q = 1'b1;
          action_q   = (value == 12'd1) ? ACT_DOWN : ACT_UP;
        end
      end
      EV_SYNC: begin
        if (!key_seen_q) action_q = ACT_MOVE;
        coord_len = 8'(leb_len(63'(pos_x_q)) + leb_len(63'(pos_y_q)) + 1);
        push_byte(MSG_HEADER[23:16], 1'b0);
        push_byte(MSG_HEADER[15:8], 1'b0);
        push_byte(MSG_HEADER[7:0], 1'b0);
        push_leb(ts);
        push_byte(SIZE_TAG_OUTER, 1'b0);
        push_byte(SIZE_BASE_OUTER + coord_len, 1'b0);
        push_byte(SIZE_TAG_INNER, 1'b0);
        push_byte(SIZE_BASE_INNER + coord_len, 1'b0);
        push_byte(TAG_X, 1'b0);
        push_leb(63'(pos_x_q));
        push_byte(TAG_Y, 1'b0);
        push_leb(63'(pos_y_q));
        push_byte(TAG_Z, 1'b0);
        push_leb('0);
        push_byte(MSG_FOOTER[23:16], 1'b0);
        push_byte(MSG_FOOTER[15:8], 1'b0);
        push_byte(MSG_FOOTER[7:0], 1'b0);
        push_byte({6'd0, action_q}, 1'b1);
        key_seen_q = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    msg_byte_t want;
    if (!rst_ni) begin
      width_q    = WIDTH_RST;
      height_q   = HEIGHT_RST;
      pos_x_q    = '0;
      pos_y_q    = '0;
      action_q   = ACT_DOWN;
      key_seen_q = 1'b0;
      msg_byte_q.delete();
    end else begin
      // Bytes leave before a new event is predicted, so a sync accepted at the
      // same edge cannot be matched against its own bytes.
      if (msg_valid_i && msg_ready_i) begin
        if (msg_byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", msg_data_i, msg_last_i));
        end else begin
          want = msg_byte_q.pop_front();
          if (msg_data_i !== want.data)
            report_mismatch($sformatf("data %02h, expected %02h", msg_data_i, want.data));
          if (msg_last_i !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", msg_last_i, want.last));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_WIDTH) width_q = cfg_data_i;
        else if (cfg_index_i == CFG_HEIGHT) height_q = cfg_data_i;
      end
      if (ev_valid_i && ev_ready_i)
        encode_event(ev_user_i[4:0], ev_data_i[9:0], ev_data_i[21:10], ev_data_i[84:22]);
    end
    queued = msg_byte_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the touch event message encoder testbench: clock, reset, stimulus and verdict.
module tb_top;
  import tevme_pkg::*;

  localparam int          HALF_PERIOD     = 4;
  localparam int          RESET_CYCLES    = 5;
  localparam int          MAX_WAIT        = 12;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          END_CYCLES      = 40;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          RANDOM_PHASES   = 4;
  localparam int          ITEMS_PER_PHASE = 62;
  localparam logic [7:0]  CFG_UNUSED      = CFG_HEIGHT + 8'd1;
  localparam logic [9:0]  CODE_UNKNOWN    = 10'h3ff;
  localparam logic [4:0]  EV_OTHER        = 5'd31;
  localparam logic [62:0] TS_MAX          = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [7:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  int          mismatch_count;
  int          bytes_outstanding;
  int unsigned items_sent = 0;
  bit          no_idle = 1'b0;
  logic        byte_taken = 1'b0;
  int unsigned out_stall = 0;
  int unsigned quiet_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  touch_event_varint_message_encoder_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  tevme_msg_checker msg_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .ev_valid_i  (s_tvalid),
    .ev_ready_i  (s_tready),
    .ev_data_i   (s_tdata),
    .ev_user_i   (s_tuser),
    .msg_valid_i (m_tvalid),
    .msg_ready_i (m_tready),
    .msg_data_i  (m_tdata),
    .msg_last_i  (m_tlast),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (mismatch_count),
    .pending_o   (bytes_outstanding)
  );

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Timestamps of every varint length, the top bit included.
  function automatic logic [62:0] rand_ts();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return 63'(r >> $urandom_range(0, 63));
  endfunction

  function automatic logic [11:0] rand_raw();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
    return 12'($urandom_range(0, 4095));
  endfunction

  // The output side stalls for a fresh random count after every byte it takes.
  always @(posedge clk) byte_taken <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (byte_taken) out_stall = draw_wait();
    else if (out_stall != 0) out_stall--;
    m_tready <= (out_stall == 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_event(logic [4:0] ev_type, logic [9:0] code, logic [11:0] value,
                            logic [62:0] ts);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {3'd0, ts, value, code};
    s_tuser  = {3'd0, ev_type};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Holds the event side until every queued byte is out and the block has settled.
  task automatic hold_until_drained();
    s_tvalid = 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [7:0] index, logic [11:0] value);
    cfg_index = index;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_touch_sequence();
    int unsigned n_moves;
    no_idle = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1))
        send_event(EV_KEY, CODE_TOUCH,
                   $urandom_range(0, 1) ? 12'd1 : 12'($urandom_range(0, 4095)), rand_ts());
      n_moves = $urandom_range(0, 2);
      repeat (n_moves) begin
        if ($urandom_range(0, 3) != 0) send_event(EV_ABS, CODE_POS_X, rand_raw(), rand_ts());
        if ($urandom_range(0, 3) != 0) send_event(EV_ABS, CODE_POS_Y, rand_raw(), rand_ts());
      end
      send_event(EV_SYNC, 10'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)),
                 rand_ts());
    end else if ($urandom_range(0, 1)) begin
      send_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)),
                 12'($urandom_range(0, 4095)), rand_ts());
    end else begin
      // A known type with a code that is almost always not one it acts on.
      send_event($urandom_range(0, 1) ? EV_ABS : EV_KEY, 10'($urandom_range(0, 1023)),
                 rand_raw(), rand_ts());
    end
    if ($urandom_range(0, 19) == 0) hold_until_drained();
  endtask

  initial begin
    int unsigned phase_end;
    logic [11:0] new_width;
    logic [11:0] new_height;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset sizes: a sync straight out of reset, full-scale positions, every key state.
    send_event(EV_SYNC, 10'd0, 12'd0, 63'd0);
    send_event(EV_ABS, CODE_POS_X, 12'd4095, 63'd0);
    send_event(EV_ABS, CODE_POS_Y, 12'd4095, 63'd0);
    send_event(EV_KEY, CODE_TOUCH, 12'd1, 63'd0);
    send_event(EV_SYNC, 10'd0, 12'd0, TS_MAX);
    send_event(EV_KEY, CODE_TOUCH, 12'd0, 63'd0);
    send_event(EV_SYNC, 10'd0, 12'd0, 63'd127);
    send_event(EV_KEY, CODE_TOUCH, 12'd4095, 63'd0);
    send_event(EV_OTHER, CODE_POS_X, 12'd5, TS_MAX);
    send_event(EV_ABS - 5'd1, CODE_TOUCH, 12'd1, 63'd0);
    send_event(EV_ABS, CODE_UNKNOWN, 12'd4095, 63'd0);
    send_event(EV_KEY, CODE_POS_X, 12'd1, 63'd0);
    send_event(EV_SYNC, 10'd0, 12'd0, 63'd128);
    send_event(EV_ABS, CODE_POS_X, 12'd0, 63'd0);
    send_event(EV_ABS, CODE_POS_Y, 12'd1, 63'd0);
    send_event(EV_SYNC, CODE_UNKNOWN, 12'd4095, rand_ts());

    // Largest sizes give two-byte coordinate varints and the longest message.
    hold_until_drained();
    write_cfg(CFG_WIDTH, 12'd4095);
    write_cfg(CFG_HEIGHT, 12'd4095);
    write_cfg(CFG_UNUSED, 12'd1);
    send_event(EV_ABS, CODE_POS_X, 12'd4095, 63'd0);
    send_event(EV_ABS, CODE_POS_Y, 12'd2048, 63'd0);
    send_event(EV_KEY, CODE_TOUCH, 12'd1, 63'd0);
    send_event(EV_SYNC, 10'd0, 12'd0, TS_MAX);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          new_width  = 12'd0;
          new_height = 12'd1;
        end
        2: begin
          new_width  = 12'd1;
          new_height = 12'd4095;
        end
        default: begin
          new_width  = 12'($urandom_range(1, 4095));
          new_height = 12'($urandom_range(1, 4095));
        end
      endcase
      hold_until_drained();
      write_cfg(CFG_WIDTH, new_width);
      write_cfg(CFG_HEIGHT, new_height);
      if (phase == 1) write_cfg(8'($urandom_range(CFG_UNUSED, 255)), 12'($urandom_range(0, 4095)));
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) random_touch_sequence();
    end

    s_tvalid = 1'b0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && bytes_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
